[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int QDEPTH_DEF = 4;

   // decode modes
   localparam logic [2:0] MODE_PLAIN   = 3'd0;
   localparam logic [2:0] MODE_ESC     = 3'd1;
   localparam logic [2:0] MODE_HEX1    = 3'd2;
   localparam logic [2:0] MODE_HIGH    = 3'd3;
   localparam logic [2:0] MODE_HIGH_BS = 3'd4;
   localparam logic [2:0] MODE_HEX2    = 3'd5;

   // error codes
   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_UNTERMINATED  = 4'd1;
   localparam logic [3:0] ERR_CONTROL       = 4'd2;
   localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd3;
   localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
   localparam logic [3:0] ERR_TRUNC_UNICODE = 4'd5;
   localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
   localparam logic [3:0] ERR_LONE_HIGH     = 4'd7;
   localparam logic [3:0] ERR_BAD_LOW       = 4'd8;
   localparam logic [3:0] ERR_LONE_LOW      = 4'd9;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // one decoded input beat: up to four result beats
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            has_byte;
      logic            done;
      logic [3:0]      err;
   } job_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic job_type byte_job(input logic [7:0] b);
      job_type j;
      j = '0;
      j.data[0]  = b;
      j.has_byte = 1'b1;
      return j;
   endfunction

   function automatic job_type flag_job(input logic done, input logic [3:0] err);
      job_type j;
      j = '0;
      j.done = done;
      j.err  = err;
      return j;
   endfunction

   function automatic job_type utf8_job(input logic [20:0] cp);
      job_type j;
      j = '0;
      j.has_byte = 1'b1;
      if (cp < 21'h80) begin
         j.data[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         j.data[0]  = {3'b110, cp[10:6]};
         j.data[1]  = {2'b10, cp[5:0]};
         j.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         j.data[0]  = {4'b1110, cp[15:12]};
         j.data[1]  = {2'b10, cp[11:6]};
         j.data[2]  = {2'b10, cp[5:0]};
         j.last_idx = 2'd2;
      end else begin
         j.data[0]  = {5'b11110, cp[20:18]};
         j.data[1]  = {2'b10, cp[17:12]};
         j.data[2]  = {2'b10, cp[11:6]};
         j.data[3]  = {2'b10, cp[5:0]};
         j.last_idx = 2'd3;
      end
      return j;
   endfunction

endpackage

[sv/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string body into UTF-8 bytes, with close and error reports.
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// req      in   tdata[7:0] raw byte; tuser[0] text ended
// rsp      out  tdata[7:0] byte; tuser has_byte, string_done, error_code; tlast
//
// Input takes one byte per cycle while the job queue is not full.
// Output sends one result beat per cycle while rsp_tready is high; a \u escape
// yields up to three beats and a surrogate pair four, so the result sequencer
// sets sustained rate; each job passes the job queue, then the result register.
// Reset is synchronous and returns the decoder to plain mode, queue empty.
// req_tready drops only while the job queue (QDEPTH jobs) is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
   parameter int QDEPTH = QDEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] text_ended
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [5:0] rsp_tuser,   // [0] has_byte, [1] string_done, [5:2] error_code
   output logic       rsp_tlast
);

   logic    job_push;
   job_type push_job;
   logic    q_full;
   logic    q_pop;
   job_type pop_job;
   logic    q_valid;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tuser),
      .job_push (job_push),
      .job      (push_job),
      .q_full   (q_full)
   );

   jsu_queue #(
      .QDEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_job   (pop_job),
      .not_empty (q_valid)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Takes raw string-body bytes, runs the escape decoder, pushes result jobs.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_end,
   output logic       job_push,
   output job_type    job,
   input  logic       q_full
);

   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  hi_ff, hi_in;
   logic        emit;
   logic        accept;
   logic [4:0]  hv;
   logic [15:0] acc_new;
   logic [10:0] cp_top;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign job_push = accept && emit;
   assign hv       = hex_value(in_byte);
   assign acc_new  = {acc_ff[11:0], hv[3:0]};
   assign cp_top   = {1'b0, hi_ff} + 11'h040;

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      hi_in   = hi_ff;
      emit    = 1'b0;
      job     = '0;
      if (in_end) begin
         emit    = 1'b1;
         mode_in = MODE_PLAIN;
         cnt_in  = '0;
         acc_in  = '0;
         case (mode_ff)
            MODE_ESC:                job = flag_job(1'b0, ERR_TRUNC_ESCAPE);
            MODE_HEX1, MODE_HEX2:    job = flag_job(1'b0, ERR_TRUNC_UNICODE);
            MODE_HIGH, MODE_HIGH_BS: job = flag_job(1'b0, ERR_LONE_HIGH);
            default:                 job = flag_job(1'b0, ERR_UNTERMINATED);
         endcase
      end else begin
         case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_PLAIN;
               cnt_in  = '0;
               acc_in  = '0;
               emit    = 1'b1;
               case (in_byte)
                  CH_QUOTE, CH_BACKSLASH, CH_SLASH: job = byte_job(in_byte);
                  CH_B: job = byte_job(8'h08);
                  CH_F: job = byte_job(8'h0C);
                  CH_N: job = byte_job(8'h0A);
                  CH_R: job = byte_job(8'h0D);
                  CH_T: job = byte_job(8'h09);
                  CH_U: begin
                     emit    = 1'b0;
                     mode_in = MODE_HEX1;
                  end
                  default: job = flag_job(1'b0, ERR_BAD_ESCAPE);
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hv[4]) begin
                  emit    = 1'b1;
                  job     = flag_job(1'b0, ERR_BAD_HEX);
                  mode_in = MODE_PLAIN;
                  cnt_in  = '0;
                  acc_in  = '0;
               end else if (cnt_ff != 2'd3) begin
                  acc_in = acc_new;
                  cnt_in = cnt_ff + 2'd1;
               end else begin
                  mode_in = MODE_PLAIN;
                  cnt_in  = '0;
                  acc_in  = '0;
                  if (mode_ff == MODE_HEX1) begin
                     if (acc_new[15:10] == 6'b110110) begin
                        hi_in   = acc_new[9:0];
                        mode_in = MODE_HIGH;
                     end else if (acc_new[15:10] == 6'b110111) begin
                        emit = 1'b1;
                        job  = flag_job(1'b0, ERR_LONE_LOW);
                     end else begin
                        emit = 1'b1;
                        job  = utf8_job({5'd0, acc_new});
                     end
                  end else begin
                     emit = 1'b1;
                     if (acc_new[15:10] != 6'b110111) begin
                        job = flag_job(1'b0, ERR_BAD_LOW);
                     end else begin
                        job = utf8_job({cp_top, acc_new[9:0]});
                     end
                  end
               end
            end
            MODE_HIGH: begin
               if (in_byte != CH_BACKSLASH) begin
                  emit    = 1'b1;
                  job     = flag_job(1'b0, ERR_LONE_HIGH);
                  mode_in = MODE_PLAIN;
                  cnt_in  = '0;
                  acc_in  = '0;
               end else begin
                  mode_in = MODE_HIGH_BS;
               end
            end
            MODE_HIGH_BS: begin
               cnt_in = '0;
               acc_in = '0;
               if (in_byte != CH_U) begin
                  emit    = 1'b1;
                  job     = flag_job(1'b0, ERR_LONE_HIGH);
                  mode_in = MODE_PLAIN;
               end else begin
                  mode_in = MODE_HEX2;
               end
            end
            default: begin
               mode_in = MODE_PLAIN;
               cnt_in  = '0;
               acc_in  = '0;
               emit    = 1'b1;
               if (in_byte == CH_QUOTE) begin
                  job = flag_job(1'b1, ERR_NONE);
               end else if (in_byte < CH_SPACE) begin
                  job = flag_job(1'b0, ERR_CONTROL);
               end else if (in_byte == CH_BACKSLASH) begin
                  emit    = 1'b0;
                  mode_in = MODE_ESC;
               end else begin
                  job = byte_job(in_byte);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         hi_ff   <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         hi_ff   <= hi_in;
      end
   end

endmodule

[sv/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Small job queue between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
   parameter int QDEPTH = QDEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    not_empty
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

   job_type       store_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Pulls queued jobs; sends result beats one per cycle when out_ready is high.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic [5:0] out_user,
   output logic       out_last
);

   job_type    cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       at_last;
   logic       sent;

   assign at_last   = (idx_ff == cur_ff.last_idx);
   assign sent      = cur_valid_ff && out_ready;
   assign q_pop     = q_valid && (!cur_valid_ff || (sent && at_last));
   assign out_valid = cur_valid_ff;
   assign out_byte  = cur_ff.data[idx_ff];
   assign out_user  = {cur_ff.err, cur_ff.done, cur_ff.has_byte};
   assign out_last  = at_last;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (q_pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (sent) begin
         if (at_last) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

endmodule
